/* hw/rtl/pnk_pkg.sv */
// ----------------------------------------------------------------------------
// pnk_pkg
// shared widths, constants, coefficient tables and the step decode of the
// pink noise generator
// ----------------------------------------------------------------------------
`default_nettype none

package pnk_pkg;

    // number formats
    localparam int STATE_FRAC_BITS = 24;
    localparam int SAMPLE_WIDTH    = 24;
    localparam int STATE_BITS      = 36;
    localparam int COEF_FRAC       = 17;
    localparam int COEF_W          = 19;
    localparam int SPLIT           = 18;
    localparam int NUM_SEC         = 6;
    localparam int SEC_W           = 3;
    localparam int GEN_W           = 32;

    localparam int WF_W      = STATE_FRAC_BITS + 1;
    localparam int SUM_W     = STATE_BITS + 4;
    localparam int SUM_HI_W  = SUM_W - SPLIT;
    localparam int OPB_W0    = (WF_W > SPLIT + 1) ? WF_W : SPLIT + 1;
    localparam int OPB_W     = (OPB_W0 > SUM_HI_W) ? OPB_W0 : SUM_HI_W;
    localparam int PROD_W    = COEF_W + OPB_W;
    localparam int ACC_W     = COEF_W + SUM_W + 2;
    localparam int OUT_SHIFT = COEF_FRAC + STATE_FRAC_BITS - (SAMPLE_WIDTH - 1);

    localparam int S_TDATA_W = GEN_W;
    localparam int M_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // generator
    localparam logic [GEN_W-1:0] LCG_MUL    = 32'd435898247;
    localparam logic [GEN_W-1:0] LCG_ADD    = 32'd382842987;
    localparam logic [GEN_W-1:0] SEED_RESET = 32'd404933;
    localparam logic [30:0]      WHITE_OFS  = 31'h40000000;

    localparam logic signed [COEF_W-1:0] LCG_MUL_HI = COEF_W'(LCG_MUL[GEN_W-1:SPLIT]);
    localparam logic signed [COEF_W-1:0] LCG_MUL_LO = COEF_W'(LCG_MUL[SPLIT-1:0]);

    // filter coefficients, q1.17
    localparam logic signed [COEF_W-1:0] POLE_COEF [NUM_SEC] = '{
        19'sd130923, 19'sd130196, 19'sd127009, 19'sd113574, 19'sd72090, -19'sd99824
    };
    localparam logic signed [COEF_W-1:0] FEED_COEF [NUM_SEC] = '{
        19'sd7277, 19'sd9840, 19'sd20166, 19'sd40696, 19'sd69855, -19'sd2215
    };
    localparam logic signed [COEF_W-1:0] DIRECT_COEF = 19'sd70281;
    localparam logic signed [COEF_W-1:0] DELAY_COEF  = 19'sd15195;
    localparam logic signed [COEF_W-1:0] GAIN_COEF   = 19'sd13763;

    // sequencer steps
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STP_LCG0  = 5'd0;
    localparam logic [STEP_W-1:0] STP_LCG1  = 5'd1;
    localparam logic [STEP_W-1:0] STP_LCG2  = 5'd2;
    localparam int                STP_SEC0  = 3;
    localparam logic [STEP_W-1:0] STP_DLY   = 5'd21;
    localparam logic [STEP_W-1:0] STP_DIR   = 5'd22;
    localparam logic [STEP_W-1:0] STP_GAIN0 = 5'd26;
    localparam logic [STEP_W-1:0] STP_GAIN1 = 5'd27;
    localparam logic [STEP_W-1:0] STP_LAST  = 5'd29;

    // result destinations
    localparam logic [2:0] DST_GEN = 3'd0;
    localparam logic [2:0] DST_SEC = 3'd1;
    localparam logic [2:0] DST_DLY = 3'd2;
    localparam logic [2:0] DST_DIR = 3'd3;
    localparam logic [2:0] DST_OUT = 3'd4;

    // second operand selects
    localparam logic [2:0] BS_SLO   = 3'd0;
    localparam logic [2:0] BS_SHI   = 3'd1;
    localparam logic [2:0] BS_STLO  = 3'd2;
    localparam logic [2:0] BS_STHI  = 3'd3;
    localparam logic [2:0] BS_WF    = 3'd4;
    localparam logic [2:0] BS_SUMLO = 3'd5;
    localparam logic [2:0] BS_SUMHI = 3'd6;

    // one multiply-accumulate command
    typedef struct packed {
        logic                     issue;
        logic                     clear;
        logic                     shift;
        logic                     last;
        logic [2:0]               dest;
        logic [2:0]               bsel;
        logic [SEC_W-1:0]         sec;
        logic signed [COEF_W-1:0] coef;
    } op_t;

    // finished group result
    typedef struct packed {
        logic                         wr;
        logic [2:0]                   dest;
        logic [SEC_W-1:0]             sec;
        logic signed [STATE_BITS-1:0] sec_val;
        logic [SAMPLE_WIDTH-1:0]      smp;
        logic [GEN_W-1:0]             gen;
    } res_t;

    function automatic op_t op_decode(input logic [STEP_W-1:0] step);
        op_t op;
        op = '0;
        case (step)
            STP_LCG0: begin
                op.issue = 1'b1; op.clear = 1'b1; op.shift = 1'b1;
                op.bsel  = BS_SLO; op.coef = LCG_MUL_HI;
            end
            STP_LCG1: begin
                op.issue = 1'b1; op.shift = 1'b1;
                op.bsel  = BS_SHI; op.coef = LCG_MUL_LO;
            end
            STP_LCG2: begin
                op.issue = 1'b1; op.last = 1'b1; op.dest = DST_GEN;
                op.bsel  = BS_SLO; op.coef = LCG_MUL_LO;
            end
            STP_DLY: begin
                op.issue = 1'b1; op.clear = 1'b1; op.last = 1'b1; op.dest = DST_DLY;
                op.bsel  = BS_WF; op.coef = DELAY_COEF;
            end
            STP_DIR: begin
                op.issue = 1'b1; op.clear = 1'b1; op.last = 1'b1; op.dest = DST_DIR;
                op.bsel  = BS_WF; op.coef = DIRECT_COEF;
            end
            STP_GAIN0: begin
                op.issue = 1'b1; op.clear = 1'b1;
                op.bsel  = BS_SUMLO; op.coef = GAIN_COEF;
            end
            STP_GAIN1: begin
                op.issue = 1'b1; op.shift = 1'b1; op.last = 1'b1; op.dest = DST_OUT;
                op.bsel  = BS_SUMHI; op.coef = GAIN_COEF;
            end
            default: begin
                op = '0;
            end
        endcase
        // three steps per section: pole * state lo, pole * state hi, feed * white
        for (int k = 0; k < NUM_SEC; k++) begin
            if (step == STEP_W'(STP_SEC0 + 3 * k)) begin
                op.issue = 1'b1; op.clear = 1'b1; op.sec = SEC_W'(k);
                op.bsel  = BS_STLO; op.coef = POLE_COEF[k];
            end
            if (step == STEP_W'(STP_SEC0 + 3 * k + 1)) begin
                op.issue = 1'b1; op.shift = 1'b1; op.sec = SEC_W'(k);
                op.bsel  = BS_STHI; op.coef = POLE_COEF[k];
            end
            if (step == STEP_W'(STP_SEC0 + 3 * k + 2)) begin
                op.issue = 1'b1; op.last = 1'b1; op.dest = DST_SEC; op.sec = SEC_W'(k);
                op.bsel  = BS_WF; op.coef = FEED_COEF[k];
            end
        end
        return op;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pnk_mac.sv */
// ----------------------------------------------------------------------------
// pnk_mac
// shared multiplier with registered product, accumulator and a result stage
// that rounds and saturates each finished group
// ----------------------------------------------------------------------------
`default_nettype none

module pnk_mac
    import pnk_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire op_t                     op,
    input  wire logic signed [OPB_W-1:0] opb,
    output res_t                         res
);

    localparam int SQ_W = ACC_W - COEF_FRAC;
    localparam int OQ_W = ACC_W - OUT_SHIFT;

    typedef struct packed {
        logic             issue;
        logic             clear;
        logic             shift;
        logic             last;
        logic [2:0]       dest;
        logic [SEC_W-1:0] sec;
    } tag_t;

    logic signed [PROD_W-1:0] prod_reg;
    tag_t                     tag_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     wb_reg;
    logic [2:0]               wb_dest_reg;
    logic [SEC_W-1:0]         wb_sec_reg;

    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] rnd_const;
    logic signed [ACC_W-1:0] added;
    logic signed [SQ_W-1:0]  sec_q;
    logic signed [OQ_W-1:0]  out_q;

    // product stage
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op.coef * opb);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= '{op.issue, op.clear, op.shift, op.last, op.dest, op.sec};
        end
    end

    // accumulate stage
    always_comb begin
        prod_ext = ACC_W'(prod_reg);
        addend   = tag_reg.shift ? (prod_ext <<< SPLIT) : prod_ext;
        acc_next = acc_reg;
        if (tag_reg.issue) begin
            acc_next = (tag_reg.clear ? '0 : acc_reg) + addend;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg <= 1'b0;
        end else begin
            wb_reg <= tag_reg.issue && tag_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        wb_dest_reg <= tag_reg.dest;
        wb_sec_reg  <= tag_reg.sec;
    end

    // result stage: round half up, then saturate
    always_comb begin
        rnd_const = (wb_dest_reg == DST_OUT) ? (ACC_W'(1) <<< (OUT_SHIFT - 1))
                                             : (ACC_W'(1) <<< (COEF_FRAC - 1));
        added = acc_reg + rnd_const;
        sec_q = added[ACC_W-1:COEF_FRAC];
        out_q = added[ACC_W-1:OUT_SHIFT];

        res.wr   = wb_reg;
        res.dest = wb_dest_reg;
        res.sec  = wb_sec_reg;
        res.gen  = acc_reg[GEN_W-1:0] + LCG_ADD;

        if ((&sec_q[SQ_W-1:STATE_BITS-1]) || !(|sec_q[SQ_W-1:STATE_BITS-1])) begin
            res.sec_val = sec_q[STATE_BITS-1:0];
        end else begin
            res.sec_val = {sec_q[SQ_W-1], {(STATE_BITS-1){~sec_q[SQ_W-1]}}};
        end

        if ((&out_q[OQ_W-1:SAMPLE_WIDTH-1]) || !(|out_q[OQ_W-1:SAMPLE_WIDTH-1])) begin
            res.smp = out_q[SAMPLE_WIDTH-1:0];
        end else begin
            res.smp = {out_q[OQ_W-1], {(SAMPLE_WIDTH-1){~out_q[OQ_W-1]}}};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pnk_seq.sv */
// ----------------------------------------------------------------------------
// pnk_seq
// step counter that drives the shared multiply-accumulate unit for one tick
// ----------------------------------------------------------------------------
`default_nettype none

module pnk_seq
    import pnk_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire logic out_full,
    output op_t       op,
    output logic      busy
);

    logic              run_reg;
    logic [STEP_W-1:0] step_reg;
    logic              hold;

    // the first gain step waits until the result register can take a new sample
    assign hold = (step_reg == STP_GAIN0) && out_full;
    assign busy = run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            step_reg <= '0;
        end else if (run_reg && !hold) begin
            if (step_reg == STP_LAST) begin
                run_reg <= 1'b0;
            end else begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_comb begin
        op = '0;
        if (run_reg && !hold) begin
            op = op_decode(step_reg);
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pink_noise_generator_top.sv */
// ----------------------------------------------------------------------------
// pink_noise_generator_top
// pink noise source: lcg white noise through a six-section one-pole bank
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: s_tuser is the action (0 = make one sample,
//   1 = load seed), s_tdata carries the 32-bit seed, read only on a reseed
//   output channel m_*: one signed q1.23 sample per tick item in m_tdata
//   a reseed item gives no result and leaves s_tready high
//   a tick item makes 25 passes through one 19x25 multiplier with an
//   accumulator behind it; the product and accumulate registers plus the
//   round/saturate stage give the sample, which is kept in the output register
//   s_tready is low while a tick is in work
//   when the receiver stalls, the sample waits in the output register;
//   a following tick runs until its gain step and waits there until the
//   output register is free, so no sample is lost or overwritten
//   reset loads the generator with 404933 and clears all filter states
// ----------------------------------------------------------------------------
`default_nettype none

module pink_noise_generator_top
    import pnk_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] seed_value
    input  wire logic                  s_tuser,   // [0] action
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata    // [23:0] pink_sample
);

    // generator and filter state
    logic [GEN_W-1:0]             gen_reg;
    logic signed [STATE_BITS-1:0] sec_reg [NUM_SEC];
    logic signed [STATE_BITS-1:0] dly_reg;

    // per-tick working values
    logic signed [WF_W-1:0]       wf_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic                         add_reg;
    logic signed [STATE_BITS-1:0] add_val_reg;

    // result register
    logic                         m_valid_reg;
    logic [SAMPLE_WIDTH-1:0]      m_data_reg;

    logic                         busy;
    logic                         in_take;
    logic                         tick_take;
    logic                         seed_take;
    op_t                          op;
    res_t                         res;
    logic signed [OPB_W-1:0]      opb;
    logic signed [STATE_BITS-1:0] sec_cur;
    logic [30:0]                  white;

    assign s_tready  = !busy;
    assign in_take   = s_tvalid && s_tready;
    assign tick_take = in_take && !s_tuser;
    assign seed_take = in_take && s_tuser;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

    // white sample in q1.30, then floored down to the state format
    assign white = gen_reg[30:0] - WHITE_OFS;

    pnk_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (tick_take),
        .out_full (m_valid_reg && !m_tready),
        .op       (op),
        .busy     (busy)
    );

    // second multiplier operand: halves of wide values, lower half unsigned
    always_comb begin
        sec_cur = sec_reg[op.sec];
        case (op.bsel)
            BS_SLO:   opb = OPB_W'(gen_reg[SPLIT-1:0]);
            BS_SHI:   opb = OPB_W'(gen_reg[GEN_W-1:SPLIT]);
            BS_STLO:  opb = OPB_W'(sec_cur[SPLIT-1:0]);
            BS_STHI:  opb = OPB_W'($signed(sec_cur[STATE_BITS-1:SPLIT]));
            BS_WF:    opb = OPB_W'(wf_reg);
            BS_SUMLO: opb = OPB_W'(sum_reg[SPLIT-1:0]);
            BS_SUMHI: opb = OPB_W'($signed(sum_reg[SUM_W-1:SPLIT]));
            default:  opb = '0;
        endcase
    end

    pnk_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .opb     (opb),
        .res     (res)
    );

    // state updates from reseed items and finished groups
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= SEED_RESET;
            for (int k = 0; k < NUM_SEC; k++) begin
                sec_reg[k] <= '0;
            end
            dly_reg <= '0;
        end else begin
            if (seed_take) begin
                gen_reg <= s_tdata;
            end
            if (res.wr) begin
                case (res.dest)
                    DST_GEN: gen_reg <= res.gen;
                    DST_SEC: sec_reg[res.sec] <= res.sec_val;
                    DST_DLY: dly_reg <= res.sec_val;
                    default: ;
                endcase
            end
        end
    end

    // sum starts from the old delayed term, sections and direct term add in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_reg <= 1'b0;
        end else begin
            add_reg <= res.wr && ((res.dest == DST_SEC) || (res.dest == DST_DIR));
        end
    end

    always_ff @(posedge aclk) begin
        add_val_reg <= res.sec_val;
        if (tick_take) begin
            wf_reg  <= white[30:30-STATE_FRAC_BITS];
            sum_reg <= SUM_W'(dly_reg);
        end else if (add_reg) begin
            sum_reg <= sum_reg + SUM_W'(add_val_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.wr && (res.dest == DST_OUT)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.wr && (res.dest == DST_OUT)) begin
            m_data_reg <= res.smp;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pnk_checker.sv */
// ----------------------------------------------------------------------------
// pnk_checker
// port-level checks of the pink noise generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pnk_checker
    import pnk_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // stalled sample stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("sample dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("sample changed while stalled");

    // a tick keeps the block busy
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("ready right after a tick item");

    // a reseed leaves the block ready
    a_seed_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> s_tready)
        else $error("reseed item left block busy");

    // no sample can appear right after a tick is taken
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("sample appeared too early");

endmodule

bind pink_noise_generator_top pnk_checker u_pnk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/pink_noise_generator_top_test.sv */
// ----------------------------------------------------------------------------
// pink_noise_generator_top_test
// self-checking bench for the pink noise generator: a directed table of
// reseeds and ticks, then random reseed/tick sequences with long runs of a
// held white value that drive the output into saturation; every sample is
// compared against a bit-exact fixed-point predictor while both channels
// idle and stall at random
// ----------------------------------------------------------------------------

module pink_noise_generator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // what an input item asks for, carried in s_tuser
    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_SEED = 1'b1
    } pink_action_e;

    localparam int SW        = pnk_pkg::SAMPLE_WIDTH;
    localparam int FRAC      = pnk_pkg::STATE_FRAC_BITS;
    localparam int SEC_BITS  = 36;
    localparam int OUT_SHIFT = 17 + FRAC - (SW - 1);

    localparam int     ITEM_TARGET  = 400;
    localparam int     MAX_GAP      = 6;
    localparam int     LONG_HOLD    = 200;   // receiver hold-off, several ticks long
    localparam int     HOLD_AT      = 40;    // samples seen before the hold-off
    localparam int     DRAIN_CYCLES = 40;    // a bit more than one tick of work
    localparam longint CYCLE_LIMIT  = 400000;

    // generator and filter constants, coefficients in q1.17
    localparam logic [31:0] LCG_MUL    = 32'd435898247;
    localparam logic [31:0] LCG_ADD    = 32'd382842987;
    localparam logic [31:0] RESET_SEED = 32'd404933;
    localparam longint WHITE_HALF  = 64'sd1073741824;
    localparam longint DIRECT_GAIN = 64'sd70281;
    localparam longint DELAY_GAIN  = 64'sd15195;
    localparam longint OUTPUT_GAIN = 64'sd13763;
    localparam longint POLE [6] = '{130923, 130196, 127009, 113574, 72090, -99824};
    localparam longint FEED [6] = '{7277, 9840, 20166, 40696, 69855, -2215};

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [pnk_pkg::S_TDATA_W-1:0] s_tdata;   // [31:0] seed_value
    logic                      s_tuser;       // [0] action
    logic                      m_tvalid;
    logic                      m_tready;
    logic [pnk_pkg::M_TDATA_W-1:0] m_tdata;   // [23:0] pink_sample

    pink_noise_generator_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor state: generator, six section states, delayed term
    // ------------------------------------------------------------------
    logic [31:0]   lcg_state;
    longint        pole_state [6];
    longint        delay_term;
    logic [SW-1:0] pending_samples [$];   // expected samples, oldest first

    int items_sent;
    int ticks_sent;
    int reseeds_sent;
    int samples_checked;
    int sat_hi_count;
    int sat_lo_count;
    int mismatches;
    bit sender_eager;                     // no idle cycles between items

    // round half up from q*.41 products back to the state format
    function automatic longint round_q17(input longint x);
        return (x + 64'sd65536) >>> 17;
    endfunction

    function automatic longint clamp_bits(input longint x, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // one tick: draw white, run the section bank, scale and saturate
    function automatic logic [SW-1:0] next_pink_sample();
        longint white;
        longint wf;
        longint total;
        longint scaled;
        longint top;
        white     = longint'({1'b0, lcg_state[30:0]}) - WHITE_HALF;
        lcg_state = lcg_state * LCG_MUL + LCG_ADD;
        wf        = white >>> (30 - FRAC);
        total     = delay_term;   // delayed term from the previous tick
        for (int k = 0; k < 6; k++) begin
            pole_state[k] = clamp_bits(round_q17(POLE[k] * pole_state[k] + FEED[k] * wf),
                                       SEC_BITS);
            total += pole_state[k];
        end
        total     += round_q17(DIRECT_GAIN * wf);
        delay_term = round_q17(DELAY_GAIN * wf);
        scaled     = (OUTPUT_GAIN * total + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        top        = (64'sd1 <<< (SW - 1)) - 1;
        if (scaled > top) sat_hi_count++;
        if (scaled < -top - 1) sat_lo_count++;
        scaled = clamp_bits(scaled, SW);
        return scaled[SW-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // sender: idle a random number of cycles, offer the item, wait for
    // the handshake, then update the predictor
    // ------------------------------------------------------------------
    task automatic send_item(input pink_action_e act, input logic [31:0] seed,
                             input bit known, input logic [SW-1:0] typed);
        int gap;
        logic [SW-1:0] predicted;
        gap = sender_eager ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= seed;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (act == ACT_SEED) begin
            lcg_state = seed;
            reseeds_sent++;
        end else begin
            predicted = next_pink_sample();
            pending_samples.push_back(known ? typed : predicted);
            ticks_sent++;
        end
    endtask

    // stop offering and wait until every sample due has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_samples.size() != 0);
    endtask

    // reseed with the same value before each tick: white stays constant,
    // so the slow sections charge up and the output runs into saturation
    task automatic held_run(input logic [31:0] seed, input int pairs);
        repeat (pairs) begin
            send_item(ACT_SEED, seed, 1'b0, '0);
            send_item(ACT_TICK, $urandom, 1'b0, '0);
        end
    endtask

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 4))
            0: return 32'h7fffffff;
            1: return 32'h00000000;
            2: return 32'hffffffff;
            3: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // directed table; a sample is typed in only where white is exactly
    // zero on cleared filter states, so the sample must be zero
    // ------------------------------------------------------------------
    typedef struct packed {
        pink_action_e  act;
        logic [31:0]   seed;
        logic          known;
        logic [SW-1:0] sample;
    } stim_row_t;

    stim_row_t directed_rows [22] = '{
        '{ACT_SEED, 32'h40000000, 1'b0, '0},   // white of exactly zero
        '{ACT_TICK, 32'hffffffff, 1'b1, '0},   // cleared states give zero
        '{ACT_SEED, 32'hc0000000, 1'b0, '0},   // top bit is masked off white
        '{ACT_TICK, 32'h00000000, 1'b1, '0},
        '{ACT_SEED, 32'h00062dc5, 1'b0, '0},   // the reset seed again
        '{ACT_TICK, 32'h00000000, 1'b0, '0},
        '{ACT_TICK, 32'hffffffff, 1'b0, '0},
        '{ACT_SEED, 32'h7fffffff, 1'b0, '0},   // largest positive white
        '{ACT_TICK, 32'h00000000, 1'b0, '0},
        '{ACT_SEED, 32'hffffffff, 1'b0, '0},
        '{ACT_TICK, 32'h00000000, 1'b0, '0},
        '{ACT_SEED, 32'h00000000, 1'b0, '0},   // white of exactly minus one
        '{ACT_TICK, 32'hffffffff, 1'b0, '0},
        '{ACT_SEED, 32'h80000000, 1'b0, '0},
        '{ACT_TICK, 32'hffffffff, 1'b0, '0},
        '{ACT_SEED, 32'h5a5a5a5a, 1'b0, '0},   // back-to-back reseeds, last one wins
        '{ACT_SEED, 32'ha5a5a5a5, 1'b0, '0},
        '{ACT_TICK, 32'h12345678, 1'b0, '0},
        '{ACT_TICK, 32'h00000000, 1'b0, '0},
        '{ACT_TICK, 32'hffffffff, 1'b0, '0},
        '{ACT_SEED, 32'h3fffffff, 1'b0, '0},   // white just below zero
        '{ACT_TICK, 32'h00000000, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // stimulus and final verdict
    // ------------------------------------------------------------------
    initial begin : stimulus
        int burst;
        logic [31:0] seed;
        lcg_state       = RESET_SEED;
        pole_state      = '{default: 0};
        delay_term      = 0;
        items_sent      = 0;
        ticks_sent      = 0;
        reseeds_sent    = 0;
        sat_hi_count    = 0;
        sat_lo_count    = 0;
        sender_eager    = 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= ACT_TICK;
        s_tdata  <= '0;
        aresetn  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].act, directed_rows[i].seed,
                      directed_rows[i].known, directed_rows[i].sample);

        // sender pause: let the block go fully idle before the random part
        wait_drained();

        // one held run of each sign, long enough to pin the output
        held_run(32'h00000000, 40);
        held_run(32'h7fffffff, 64);

        while (items_sent < ITEM_TARGET) begin
            sender_eager = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    // plain ticks
                    burst = $urandom_range(1, 8);
                    repeat (burst) send_item(ACT_TICK, $urandom, 1'b0, '0);
                end
                8, 9, 10, 11: begin
                    // fresh random seed, then a few ticks
                    send_item(ACT_SEED, $urandom, 1'b0, '0);
                    burst = $urandom_range(1, 5);
                    repeat (burst) send_item(ACT_TICK, $urandom, 1'b0, '0);
                end
                12, 13: begin
                    seed = pick_seed();
                    held_run(seed, $urandom_range(8, 24));
                end
                14, 15: begin
                    // several reseeds in a row, only the last one counts
                    burst = $urandom_range(2, 3);
                    repeat (burst) send_item(ACT_SEED, pick_seed(), 1'b0, '0);
                    send_item(ACT_TICK, $urandom, 1'b0, '0);
                end
                default: begin
                    // unstructured mix
                    burst = $urandom_range(2, 6);
                    repeat (burst)
                        send_item(pink_action_e'($urandom_range(0, 1)), $urandom, 1'b0, '0);
                end
            endcase
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d ticks and %0d reseeds, %0d samples checked, %0d mismatches",
                 ticks_sent, reseeds_sent, samples_checked, mismatches);
        $display("saturated samples: %0d at positive and %0d at negative full scale",
                 sat_hi_count, sat_lo_count);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, eager stretches, one long hold-off that
    // backs the block up until it stalls its input
    // ------------------------------------------------------------------
    initial begin : sample_sink
        int stall;
        int eager_left;
        bit held;
        logic [SW-1:0] want;
        samples_checked = 0;
        mismatches      = 0;
        eager_left      = 0;
        held            = 1'b0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held && samples_checked == HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (eager_left > 0) begin
                stall = 0;
                eager_left--;
            end else begin
                stall = $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 14) == 0) eager_left = 20;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            // item taken at this edge
            if (pending_samples.size() == 0) begin
                report_mismatch($sformatf("sample %h with none expected", m_tdata[SW-1:0]));
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata[SW-1:0] !== want)
                    report_mismatch($sformatf("pink_sample %h, expected %h (sample %0d)",
                                              m_tdata[SW-1:0], want, samples_checked));
                samples_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    initial begin : watchdog
        longint cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d samples still due",
                 cycles, pending_samples.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
